[src/falte_pkg.sv]
// Package for the frame ack lag and throughput estimator.
// Types and constants shared by the other modules but falte_ram; no dependencies.
`timescale 1ns / 1ps
package falte_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int PTR_W = SLOT_W + 1;
    localparam int TIME_W = 48;
    localparam int BYTES_W = 32;
    localparam int RENDER_W = 20;
    localparam int SUM_W = 64;
    localparam int RSUM_W = RENDER_W + PTR_W;
    localparam int REC_W = TIME_W + BYTES_W + RENDER_W;

    localparam logic [1:0] ST_ACK    = 2'd0;
    localparam logic [1:0] ST_FUTURE = 2'd1;
    localparam logic [1:0] ST_STALE  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       capture;     // latch input item
        logic       emit_drop;   // drop oldest record (full ring)
        logic       emit_write;  // write record, bump tail
        logic       scan_start;  // clear sums, reset scan index
        logic       rd_issue;    // issue RAM read at head+idx
        logic       scan_acc;    // accumulate returned record
        logic       ack_update;  // update baseline/lag, retire on match
        logic       div_net;     // start network division
        logic       div_proc;    // start processing division
        logic       fold_net;    // fold quotient into net avg
        logic       fold_proc;   // fold quotient into proc avg
        logic       set_status;  // latch status of non-scanning item
        logic [1:0] status;
    } falte_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_ack;
        logic future;
        logic stale;
        logic full;
        logic scan_done;   // scan terminated (match, later, or end)
        logic net_ok;
        logic proc_ok;
        logic div_done;
    } falte_sts_t;

endpackage

[src/falte_if.sv]
// Valid/ready channel interfaces for input and result transactions.
// Depends on nothing.
`timescale 1ns / 1ps
interface falte_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [47:0] frame_time;
    logic [47:0] now_time;
    logic [47:0] last_sent_time;
    logic [31:0] frame_size;
    logic [19:0] render_ms;
    modport source (output valid, action, frame_time, now_time, last_sent_time,
                    frame_size, render_ms, input ready);
    modport sink (input valid, action, frame_time, now_time, last_sent_time,
                  frame_size, render_ms, output ready);
endinterface

interface falte_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        matched;
    logic        consecutive;
    logic [30:0] client_lag;
    logic signed [31:0] round_trip;
    logic [30:0] net_tput;
    logic [30:0] proc_rate;
    logic [37:0] ring_bytes;
    modport source (output valid, status, matched, consecutive, client_lag,
                    round_trip, net_tput, proc_rate, ring_bytes, input ready);
    modport sink (input valid, status, matched, consecutive, client_lag,
                  round_trip, net_tput, proc_rate, ring_bytes, output ready);
endinterface

[src/falte_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module falte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/falte_div.sv]
// Radix-2 restoring divider, 64-bit dividend, one quotient bit per cycle.
// Result saturates at 2^31-1. Depends on falte_pkg.
`timescale 1ns / 1ps
module falte_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [falte_pkg::SUM_W-1:0]    num,
    input  logic [falte_pkg::SUM_W-1:0]    den,
    output logic                           done,
    output logic [30:0]                    quot
);
    localparam int W = falte_pkg::SUM_W;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] d_reg;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [W:0]   trial;
    logic [W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, q_reg[W-1]};
        diff = trial - {1'b0, d_reg};
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next = '0;
            q_next = num;
            cnt_next = 7'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start)
        begin
            d_reg <= den;
        end
    end

    assign done = busy_reg && (cnt_reg == 7'd1);
    assign quot = (q_next[W-1:31] != '0) ? falte_pkg::MAX31 : q_next[30:0];
endmodule

[src/falte_datapath.sv]
// Datapath: record ring, scan accumulators, baseline/lag math, averages.
// Depends on falte_pkg, falte_if, falte_ram, falte_div.
`timescale 1ns / 1ps
module falte_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  falte_pkg::falte_cmd_t cmd,
    output falte_pkg::falte_sts_t sts,
    falte_in_if.sink             in_ch,
    falte_out_if.source          out_ch
);
    localparam int SW = falte_pkg::SLOT_W;
    localparam int PW = falte_pkg::PTR_W;
    localparam int TW = falte_pkg::TIME_W;

    // latched item
    logic          act_reg;
    logic [TW-1:0] ts_reg, now_reg, ls_reg;
    logic [31:0]   byt_reg;
    logic [19:0]   rnd_reg;

    // architectural state
    logic [PW-1:0] head_reg, tail_reg;
    logic [TW-1:0] last_ack_reg, receipt_reg;
    logic signed [31:0] rtt_reg;
    logic [30:0]   lag_reg, net_reg, proc_reg;
    logic [falte_pkg::SUM_W-1:0] live_reg;
    logic          receipt_ok_reg;  // receipt time was nonzero before this ack

    // scan
    logic [PW-1:0] idx_reg;       // next index to issue
    logic [PW-1:0] acc_idx_reg;   // index being accumulated
    logic [falte_pkg::SUM_W-1:0] bsum_reg;
    logic [falte_pkg::RSUM_W-1:0] rsum_reg;
    logic          match_reg, consec_reg, done_reg;
    logic [PW-1:0] count;
    logic [30:0]   fpl_reg;
    logic [1:0]    status_reg;

    // ring memory
    logic [falte_pkg::REC_W-1:0] rd_data;
    logic [PW-1:0] rd_ptr;
    logic [TW-1:0] r_time;
    logic [31:0]   r_bytes;
    logic [19:0]   r_rend;

    assign count = tail_reg - head_reg;
    // scan reads at head+idx; otherwise the oldest record is read for a drop
    assign rd_ptr = cmd.rd_issue ? head_reg + idx_reg : head_reg;
    assign {r_time, r_bytes, r_rend} = rd_data;

    falte_ram #(.WIDTH(falte_pkg::REC_W), .DEPTH(falte_pkg::HISTORY_DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.emit_write),
        .waddr (tail_reg[SW-1:0]),
        .wdata ({ts_reg, byt_reg, rnd_reg}),
        .raddr (rd_ptr[SW-1:0]),
        .rdata (rd_data)
    );

    // divider
    logic        div_start, div_done;
    logic [30:0] div_q;
    logic [falte_pkg::SUM_W-1:0] div_den;
    assign div_start = cmd.div_net || cmd.div_proc;
    assign div_den = cmd.div_net ? 64'(rsum_reg) : 64'(fpl_reg);
    falte_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(bsum_reg),
        .den(div_den), .done(div_done), .quot(div_q)
    );

    // baseline math
    logic signed [49:0] elapsed;
    logic signed [31:0] duration;
    logic signed [33:0] dmr;
    logic [30:0]   fpl_c, lag_c;
    logic signed [31:0] est;

    function automatic logic [30:0] clamp31(input logic signed [49:0] v);
        if (v < 0)
            return '0;
        else if (v > 50'sh7FFF_FFFF)
            return falte_pkg::MAX31;
        else
            return v[30:0];
    endfunction

    always_comb
    begin
        elapsed = $signed({2'b00, now_reg}) - $signed({2'b00, ts_reg});
        if (elapsed > 50'sh7FFF_FFFF)
            duration = 32'sh7FFF_FFFF;
        else if (elapsed < -50'sh8000_0000)
            duration = 32'sh8000_0000;
        else
            duration = elapsed[31:0];
        dmr = 34'(duration) - 34'(rtt_reg);
        fpl_c = (rtt_reg != 0) ? clamp31(50'(dmr)) : '0;
        est = 32'(34'(duration) - 34'($signed({1'b0, fpl_c})));
        lag_c = clamp31(elapsed - 50'(est));
    end

    function automatic logic [30:0] fold(input logic [30:0] avg, input logic [30:0] s);
        logic [33:0] t;
        t = 34'(avg) * 34'd3 + 34'(s);
        if (avg == '0)
            return s;
        return t[32:2];
    endfunction

    // sequential state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            last_ack_reg <= '0;
            receipt_reg <= '0;
            receipt_ok_reg <= 1'b0;
            rtt_reg <= '0;
            lag_reg <= '0;
            net_reg <= '0;
            proc_reg <= '0;
            live_reg <= '0;
            done_reg <= 1'b0;
            match_reg <= 1'b0;
            consec_reg <= 1'b0;
            status_reg <= falte_pkg::ST_EMIT;
        end
        else
        begin
            if (cmd.emit_drop)
            begin
                head_reg <= head_reg + PW'(1);
            end
            if (cmd.emit_write)
            begin
                tail_reg <= tail_reg + PW'(1);
                live_reg <= live_reg + 64'(byt_reg) - (sts.full ? 64'(r_bytes) : 64'd0);
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
                match_reg <= 1'b0;
                consec_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                done_reg <= (count == '0);
                match_reg <= 1'b0;
                consec_reg <= 1'b0;
                status_reg <= falte_pkg::ST_ACK;
            end
            if (cmd.scan_acc && !done_reg)
            begin
                if (r_time == ts_reg)
                begin
                    match_reg <= 1'b1;
                    consec_reg <= (acc_idx_reg == '0);
                    done_reg <= 1'b1;
                end
                else if (r_time > ts_reg || acc_idx_reg + PW'(1) == count)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (cmd.ack_update)
            begin
                last_ack_reg <= ts_reg;
                rtt_reg <= est;
                lag_reg <= lag_c;
                receipt_ok_reg <= (receipt_reg != '0);
                if (match_reg)
                begin
                    head_reg <= head_reg + acc_idx_reg + PW'(1);
                    live_reg <= live_reg - bsum_reg;
                    receipt_reg <= now_reg;
                end
            end
            if (cmd.fold_net)
            begin
                net_reg <= fold(net_reg, div_q);
            end
            if (cmd.fold_proc)
            begin
                proc_reg <= fold(proc_reg, div_q);
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= in_ch.action;
            ts_reg <= in_ch.frame_time;
            now_reg <= in_ch.now_time;
            ls_reg <= in_ch.last_sent_time;
            byt_reg <= in_ch.frame_size;
            rnd_reg <= in_ch.render_ms;
        end
        if (cmd.scan_start)
        begin
            idx_reg <= '0;
            bsum_reg <= '0;
            rsum_reg <= '0;
        end
        if (cmd.rd_issue)
        begin
            acc_idx_reg <= idx_reg;
            idx_reg <= idx_reg + PW'(1);
        end
        if (cmd.scan_acc && !done_reg)
        begin
            bsum_reg <= bsum_reg + 64'(r_bytes);
            rsum_reg <= rsum_reg + falte_pkg::RSUM_W'(r_rend);
        end
        if (cmd.ack_update)
        begin
            fpl_reg <= fpl_c;
        end
    end

    assign sts.is_ack = act_reg;
    assign sts.future = ts_reg > ls_reg;
    assign sts.stale = ts_reg < last_ack_reg;
    assign sts.full = count[PW-1];
    assign sts.scan_done = done_reg;
    assign sts.net_ok = match_reg && (rsum_reg != '0);
    assign sts.proc_ok = consec_reg && receipt_ok_reg && (fpl_reg != '0);
    assign sts.div_done = div_done;

    assign out_ch.status = status_reg;
    assign out_ch.matched = match_reg;
    assign out_ch.consecutive = consec_reg;
    assign out_ch.client_lag = lag_reg;
    assign out_ch.round_trip = rtt_reg;
    assign out_ch.net_tput = net_reg;
    assign out_ch.proc_rate = proc_reg;
    assign out_ch.ring_bytes = live_reg[37:0];
endmodule

[src/falte_ctrl.sv]
// Controller state machine sequencing emit, scan, update and divisions.
// Depends on falte_pkg.
`timescale 1ns / 1ps
module falte_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output falte_pkg::falte_cmd_t cmd,
    input  falte_pkg::falte_sts_t sts
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_EMITRD = 10'b0000000100,
        S_EMITWR = 10'b0000001000,
        S_SCAN   = 10'b0000010000,
        S_UPDATE = 10'b0000100000,
        S_NETDIV = 10'b0001000000,
        S_PRCHK  = 10'b0010000000,
        S_PRDIV  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;   // a read is in flight during scan

    always_comb
    begin
        state_next = state_reg;
        pend_next = pend_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.is_ack)
                begin
                    cmd.emit_drop = 1'b0;
                    cmd.set_status = 1'b1;
                    cmd.status = falte_pkg::ST_EMIT;
                    state_next = S_EMITRD;
                end
                else if (sts.future)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = falte_pkg::ST_FUTURE;
                    state_next = S_OUT;
                end
                else if (sts.stale)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = falte_pkg::ST_STALE;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    pend_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_EMITRD:
            begin
                // read oldest record bytes (address = head)
                cmd.emit_drop = 1'b0;
                state_next = S_EMITWR;
            end
            S_EMITWR:
            begin
                cmd.emit_write = 1'b1;
                cmd.emit_drop = sts.full;
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_UPDATE;
                end
                else if (!pend_reg)
                begin
                    cmd.rd_issue = 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    cmd.scan_acc = 1'b1;
                    pend_next = 1'b0;
                end
            end
            S_UPDATE:
            begin
                cmd.ack_update = 1'b1;
                if (sts.net_ok)
                begin
                    cmd.div_net = 1'b1;
                    state_next = S_NETDIV;
                end
                else
                begin
                    state_next = S_PRCHK;
                end
            end
            S_NETDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.fold_net = 1'b1;
                    state_next = S_PRCHK;
                end
            end
            S_PRCHK:
            begin
                if (sts.proc_ok)
                begin
                    cmd.div_proc = 1'b1;
                    state_next = S_PRDIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PRDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.fold_proc = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
        end
    end
endmodule

[src/frame_ack_lag_throughput_estimator_top.sv]
// Top level of the frame ack lag and throughput estimator.
// Depends on falte_pkg, falte_if, falte_ctrl, falte_datapath.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one transaction per emitted frame (action 0) or ack
//   (action 1); out_ch returns exactly one result transaction per input.
//   Items are handled one at a time: in_ch.ready is high only while the
//   block is idle.
//   An emit passes through decode, a read of the oldest record and the
//   record write before its result is valid; a future or stale ack goes
//   from decode straight to its result. A processed ack scans the live
//   records through the ring RAM, a read and then an accumulate per
//   record (registered read), then uses the shared bit-serial divider
//   once for each throughput sample taken, at most two per ack.
//   Reset clears pointers, baseline, lag, averages and byte sum; the
//   record RAM is not cleared, since only written records are read.
//   When out_ch.ready is low the result is held stable and no new input
//   is accepted until it is taken.
module frame_ack_lag_throughput_estimator_top (
    input logic        clk,
    input logic        rst_n,
    falte_in_if.sink   in_ch,
    falte_out_if.source out_ch
);
    falte_pkg::falte_cmd_t cmd;
    falte_pkg::falte_sts_t sts;

    falte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    falte_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );
endmodule
